// ===== rtl/core/utf16le_line_codepoint_filter_macros.svh =====
// Assertion macros for the checker file of the code point filter.
`ifndef UTF16LE_LINE_CODEPOINT_FILTER_MACROS_SVH
`define UTF16LE_LINE_CODEPOINT_FILTER_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define U16F_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("same-cycle check failed");

// Next-cycle implication, disabled while in reset.
`define U16F_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("next-cycle check failed");

`endif

// ===== rtl/core/u16f_pkg.sv =====
// Types, constants and code unit values for the UTF-16 code point filter.
package u16f_pkg;

  localparam int unsigned UNIT_W  = 16;
  localparam int unsigned CP_W    = 21;
  localparam int unsigned CNT_W   = 11;
  localparam int unsigned SURR_W  = 10;

  // Hard ceiling on the per-string code point limit.
  localparam int unsigned LIMIT_MAX = 1024;
  localparam logic [CNT_W-1:0] LIM_CAP =
    (LIMIT_MAX >= (1 << CNT_W) - 1) ? {CNT_W{1'b1}} : CNT_W'(LIMIT_MAX);

  localparam logic [CNT_W-1:0] MAX_CP_RESET = CNT_W'(256);

  // Register index, taken from paddr[2].
  localparam logic REG_MAX_CODEPOINTS = 1'b0;

  // Code unit values.
  localparam logic [UNIT_W-1:0] CU_NUL      = 16'h0000;
  localparam logic [UNIT_W-1:0] CU_LF       = 16'h000a;
  localparam logic [UNIT_W-1:0] CU_CR       = 16'h000d;
  localparam logic [UNIT_W-1:0] CU_SPACE    = 16'h0020;
  localparam logic [UNIT_W-1:0] CU_DEL      = 16'h007f;
  localparam logic [UNIT_W-1:0] CU_C1_LO    = 16'h0080;
  localparam logic [UNIT_W-1:0] CU_C1_HI    = 16'h009f;
  localparam logic [5:0]        SURR_HI_TAG = 6'b110110;
  localparam logic [5:0]        SURR_LO_TAG = 6'b110111;
  localparam logic [CP_W-1:0]   SUPP_BASE   = 21'h10000;

  typedef struct packed {
    logic              last;
    logic [UNIT_W-1:0] unit;
  } item_t;

  typedef struct packed {
    logic             has_char;
    logic [CP_W-1:0]  cp;
    logic             done;
    logic [CNT_W-1:0] count;
  } result_t;

endpackage

// ===== rtl/core/u16f_cfg_regs.sv =====
// APB-style configuration register holding the code point limit.
module u16f_cfg_regs
  import u16f_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_psel,
  input  logic             cfg_penable,
  input  logic             cfg_pwrite,
  input  logic [2:0]       cfg_paddr,
  input  logic [31:0]      cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready,
  output logic [CNT_W-1:0] max_cp
);

  logic [CNT_W-1:0] max_cp_r;
  logic             wr_en;

  assign cfg_pready = 1'b1;
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready
                 && (cfg_paddr[2] == REG_MAX_CODEPOINTS);

  // Write the limit register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_cp_r <= MAX_CP_RESET;
    end else if (wr_en) begin
      max_cp_r <= cfg_pwdata[CNT_W-1:0];
    end
  end

  // Return the register value, zero elsewhere.
  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == REG_MAX_CODEPOINTS) begin
      cfg_prdata = {{(32 - CNT_W){1'b0}}, max_cp_r};
    end
  end

  assign max_cp = max_cp_r;

endmodule

// ===== rtl/core/u16f_in_stage.sv =====
// Input register for the code unit stream.
module u16f_in_stage
  import u16f_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  load,
  input  logic  advance,
  input  item_t item_in,
  output logic  valid,
  output item_t item_out
);

  logic  valid_r;
  item_t item_r;

  // Track occupancy: fill on load, empty when the item moves on.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (advance) begin
      valid_r <= 1'b0;
    end
  end

  // Capture the payload.
  always_ff @(posedge clk) begin
    if (load) begin
      item_r <= item_in;
    end
  end

  assign valid    = valid_r;
  assign item_out = item_r;

endmodule

// ===== rtl/core/u16f_decode.sv =====
// Per-string state and single-pass decode of one code unit.
module u16f_decode
  import u16f_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  item_t            item,
  input  logic [CNT_W-1:0] max_cp,
  output logic             res_valid,
  output result_t          res
);

  logic [SURR_W-1:0] held_r, held_nxt;
  logic              pend_r, pend_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              stop_r, stop_nxt;

  logic [CNT_W-1:0]  lim;
  logic [CNT_W-1:0]  cnt_inc;
  logic              lim_hit, is_term, is_hi, is_lo, is_ctrl;
  logic              emit, done;
  logic [CP_W-1:0]   cp;

  // Clamp the configured limit.
  assign lim = (max_cp > LIM_CAP) ? LIM_CAP : max_cp;

  // Classify the unit.
  assign lim_hit = (cnt_r >= lim);
  assign is_term = (item.unit == CU_NUL) || (item.unit == CU_CR) || (item.unit == CU_LF);
  assign is_hi   = (item.unit[15:10] == SURR_HI_TAG);
  assign is_lo   = (item.unit[15:10] == SURR_LO_TAG);
  assign is_ctrl = (item.unit < CU_SPACE) || (item.unit == CU_DEL)
                   || ((item.unit >= CU_C1_LO) && (item.unit <= CU_C1_HI));

  // Decide emission and form the code point.
  always_comb begin
    emit = 1'b0;
    cp   = '0;
    if (!lim_hit && !is_term && !is_hi) begin
      if (is_lo) begin
        emit = pend_r;
        cp   = SUPP_BASE + {1'b0, held_r, item.unit[SURR_W-1:0]};
      end else begin
        emit = !is_ctrl;
        cp   = {{(CP_W - UNIT_W){1'b0}}, item.unit};
      end
    end
  end

  assign cnt_inc   = cnt_r + {{(CNT_W - 1){1'b0}}, emit};
  assign done      = lim_hit || (!lim_hit && is_term) || (emit && (cnt_inc >= lim))
                     || item.last;
  assign res_valid = step && !stop_r && (emit || done);

  // Pack the result.
  always_comb begin
    res.has_char = emit;
    res.cp       = emit ? cp : '0;
    res.done     = done;
    res.count    = cnt_inc;
  end

  // Next string state.
  always_comb begin
    held_nxt = held_r;
    pend_nxt = pend_r;
    cnt_nxt  = cnt_r;
    stop_nxt = stop_r;
    if (step) begin
      if (item.last) begin
        held_nxt = '0;
        pend_nxt = 1'b0;
        cnt_nxt  = '0;
        stop_nxt = 1'b0;
      end else if (!stop_r) begin
        cnt_nxt = cnt_inc;
        if (done) begin
          stop_nxt = 1'b1;
          pend_nxt = 1'b0;
          held_nxt = '0;
        end else if (is_hi) begin
          pend_nxt = 1'b1;
          held_nxt = item.unit[SURR_W-1:0];
        end else begin
          pend_nxt = 1'b0;
          held_nxt = '0;
        end
      end
    end
  end

  // Hold the string state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_r <= '0;
      pend_r <= 1'b0;
      cnt_r  <= '0;
      stop_r <= 1'b0;
    end else begin
      held_r <= held_nxt;
      pend_r <= pend_nxt;
      cnt_r  <= cnt_nxt;
      stop_r <= stop_nxt;
    end
  end

endmodule

// ===== rtl/core/u16f_out_stage.sv =====
// Result register driving the output stream.
module u16f_out_stage
  import u16f_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  result_t res_in,
  input  logic    taken,
  output logic    valid,
  output result_t res_out
);

  logic    valid_r;
  result_t res_r;

  // Fill on load, drop once the consumer takes the transaction.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= 1'b1;
    end else if (taken) begin
      valid_r <= 1'b0;
    end
  end

  // Capture the payload.
  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res_in;
    end
  end

  assign valid   = valid_r;
  assign res_out = res_r;

endmodule

// ===== rtl/core/utf16le_line_codepoint_filter.sv =====
// An accepted code unit is held in the input register and, when it moves on, its result
// (if it yields one) is written to the result register that drives the result stream.
// Throughput: one code unit per cycle when the result stream is not stalled, set by the
// single decode pass that sits between the input register and the result register.
// The input register accepts a new unit when it is empty or its item moves on that cycle.
// Reset (synchronous, rst_n low) empties both registers, clears the string state
// and sets max_codepoints to 256.
module utf16le_line_codepoint_filter
  import u16f_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Input stream.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] code_unit
  input  logic        in_tlast,   // last_unit
  // Result stream.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [20:0] codepoint, [31:21] total_count
  output logic        out_tuser,  // has_char
  output logic        out_tlast,  // done_res
  // Configuration port.
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  logic             in_valid, advance, res_valid;
  item_t            item_in, item_q;
  result_t          res, res_q;
  logic [CNT_W-1:0] max_cp;

  u16f_cfg_regs u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .max_cp      (max_cp)
  );

  // Move the held unit on when the result register is free or being drained.
  assign advance   = in_valid && (!out_tvalid || out_tready);
  assign in_tready = !in_valid || advance;

  assign item_in = {in_tlast, in_tdata};

  u16f_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (in_tvalid && in_tready),
    .advance  (advance),
    .item_in  (item_in),
    .valid    (in_valid),
    .item_out (item_q)
  );

  u16f_decode u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (advance),
    .item      (item_q),
    .max_cp    (max_cp),
    .res_valid (res_valid),
    .res       (res)
  );

  u16f_out_stage u_out (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (res_valid),
    .res_in  (res),
    .taken   (out_tready),
    .valid   (out_tvalid),
    .res_out (res_q)
  );

  assign out_tdata = {res_q.count, res_q.cp};
  assign out_tuser = res_q.has_char;
  assign out_tlast = res_q.done;

endmodule

// ===== rtl/core/u16f_checker.sv =====
// Port-level checker for the code point filter, bound to the top level.
`include "utf16le_line_codepoint_filter_macros.svh"

module u16f_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [31:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // A result without a character only ends the string.
  `U16F_ASSERT_NOW(a_nochar_is_done, clk, rst_n, out_tvalid && !out_tuser, out_tlast)

  // A result without a character carries a zero code point.
  `U16F_ASSERT_NOW(a_nochar_zero_cp, clk, rst_n, out_tvalid && !out_tuser,
                   out_tdata[20:0] == 21'd0)

  // An emitted character is counted.
  `U16F_ASSERT_NOW(a_char_counted, clk, rst_n, out_tvalid && out_tuser,
                   out_tdata[31:21] != 11'd0)

  // Hold a stalled result.
  `U16F_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready,
                    out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast))

endmodule

bind utf16le_line_codepoint_filter u16f_checker u_chk (.*);

// ===== dv/tb.sv =====
// Self-checking testbench for the UTF-16 line code point filter.
module tb;
  import u16f_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam logic [2:0]  MAXCP_ADDR  = 3'(4 * REG_MAX_CODEPOINTS);

  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_COMB} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;   // [15:0] code_unit
  logic        in_tlast = 1'b0; // last_unit
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // [20:0] codepoint, [31:21] total_count
  logic        out_tuser;       // has_char
  logic        out_tlast;       // done_res
  logic        cfg_psel = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite = 1'b0;
  logic [2:0]  cfg_paddr = '0;
  logic [31:0] cfg_pwdata = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // Predictor copy of the register and the string state.
  logic [CNT_W-1:0]  lim_reg = MAX_CP_RESET;
  logic [SURR_W-1:0] held_bits = '0;
  bit                high_pend = 1'b0;
  int unsigned       cp_count = 0;
  bit                halted = 1'b0;

  result_t decoded_q[$];
  int      errors = 0;
  int      sent_units = 0;
  int      burst_left = 0;
  bit      gaps_on = 1'b0;
  rx_mode_t rx_mode = RX_OPEN;
  int      stall_phase = 0;

  utf16le_line_codepoint_filter dut (
    .clk(clk), .rst_n(rst_n),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata), .in_tlast(in_tlast),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tuser(out_tuser), .out_tlast(out_tlast),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg_pready(cfg_pready)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // End the run if it hangs.
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  function automatic void note_error(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endfunction

  function automatic void start_new_string();
    held_bits = '0;
    high_pend = 1'b0;
    cp_count = 0;
    halted = 1'b0;
  endfunction

  function automatic bit is_control(input logic [UNIT_W-1:0] unit);
    return unit < CU_SPACE || unit == CU_DEL || (unit >= CU_C1_LO && unit <= CU_C1_HI);
  endfunction

  // Work out the result, if any, that one code unit causes.
  function automatic bit decode_unit(input logic [UNIT_W-1:0] unit, input logic last,
                                     output result_t res);
    int unsigned     lim;
    bit              emit;
    bit              done;
    logic [CP_W-1:0] cp;
    lim = (lim_reg > LIMIT_MAX) ? LIMIT_MAX : lim_reg;
    emit = 1'b0;
    done = 1'b0;
    cp = '0;
    res = '0;
    if (halted) begin
      if (last) start_new_string();
      return 1'b0;
    end
    if (cp_count >= lim) begin
      done = 1'b1;
      high_pend = 1'b0;
      held_bits = '0;
    end else if (unit == CU_NUL || unit == CU_CR || unit == CU_LF) begin
      done = 1'b1;
      high_pend = 1'b0;
      held_bits = '0;
    end else if (unit[15:10] == SURR_HI_TAG) begin
      held_bits = unit[SURR_W-1:0];
      high_pend = 1'b1;
    end else if (unit[15:10] == SURR_LO_TAG) begin
      if (high_pend) begin
        cp = SUPP_BASE + CP_W'({held_bits, unit[SURR_W-1:0]});
        emit = 1'b1;
      end
      high_pend = 1'b0;
      held_bits = '0;
    end else begin
      high_pend = 1'b0;
      held_bits = '0;
      if (!is_control(unit)) begin
        cp = CP_W'(unit);
        emit = 1'b1;
      end
    end
    if (emit) begin
      cp_count++;
      if (cp_count >= lim) done = 1'b1;
    end
    if (last) done = 1'b1;
    if (!emit && !done) return 1'b0;
    res.has_char = emit;
    res.cp       = cp;
    res.done     = done;
    res.count    = CNT_W'(cp_count);
    if (last) begin
      start_new_string();
    end else if (done) begin
      halted = 1'b1;
      high_pend = 1'b0;
      held_bits = '0;
    end
    return 1'b1;
  endfunction

  // Predict on every accepted input transaction.
  always @(posedge clk) begin
    result_t res;
    if (rst_n && in_tvalid && in_tready === 1'b1) begin
      if (decode_unit(in_tdata, in_tlast, res)) decoded_q.push_back(res);
    end
  end

  // Compare every accepted result transaction with the oldest prediction.
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      got.has_char = out_tuser;
      got.cp       = out_tdata[CP_W-1:0];
      got.done     = out_tlast;
      got.count    = out_tdata[31:CP_W];
      if (decoded_q.size() == 0) begin
        note_error($sformatf("unexpected result: has_char=%0b cp=%h done=%0b count=%0d",
                             got.has_char, got.cp, got.done, got.count));
      end else begin
        want = decoded_q.pop_front();
        if (got !== want)
          note_error($sformatf({"result mismatch: expected has_char=%0b cp=%h done=%0b ",
                                "count=%0d, got has_char=%0b cp=%h done=%0b count=%0d"},
                               want.has_char, want.cp, want.done, want.count,
                               got.has_char, got.cp, got.done, got.count));
      end
    end
  end

  // Drive the result ready on the selected stall pattern.
  always @(posedge clk) begin
    stall_phase++;
    case (rx_mode)
      RX_OPEN:   out_tready <= 1'b1;
      RX_RANDOM: out_tready <= ($urandom_range(0, 99) >= 35);
      default:   out_tready <= (stall_phase % 9) < 5;
    endcase
  end

  // Send one code unit; hold it until the handshake completes.
  task automatic send_unit(input logic [UNIT_W-1:0] unit, input logic last);
    int gap;
    gap = 0;
    if (gaps_on) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 16);
        gap = $urandom_range(1, 8);
      end
      burst_left--;
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= unit;
    in_tlast  <= last;
    @(posedge clk);
    while (in_tready !== 1'b1) @(posedge clk);
    sent_units++;
  endtask

  // Stop sending and let every prediction drain, then let the pipeline settle.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Read max_codepoints back and compare with the predictor copy.
  task automatic cfg_read_check();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= MAXCP_ADDR;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    if (cfg_prdata[CNT_W-1:0] !== lim_reg)
      note_error($sformatf("register readback: expected %0d, got %0d",
                           lim_reg, cfg_prdata[CNT_W-1:0]));
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write max_codepoints, then read it back.
  task automatic set_limit(input logic [CNT_W-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= MAXCP_ADDR;
    cfg_pwdata  <= 32'(value);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (cfg_pready !== 1'b1) @(posedge clk);
    lim_reg = value;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    cfg_read_check();
  endtask

  // Pick a printable BMP unit that is neither a surrogate nor a control.
  function automatic logic [UNIT_W-1:0] pick_text_unit();
    case ($urandom_range(0, 3))
      0:       return UNIT_W'($urandom_range(16'h0020, 16'h007e));
      1:       return UNIT_W'($urandom_range(16'h00a0, 16'hd7ff));
      2:       return UNIT_W'($urandom_range(16'he000, 16'hffff));
      default: return UNIT_W'($urandom_range(16'h0100, 16'h07ff));
    endcase
  endfunction

  // Pick a unit that breaks the flow: lone surrogate, control, terminator, or anything.
  function automatic logic [UNIT_W-1:0] pick_noise_unit();
    case ($urandom_range(0, 5))
      0:       return {SURR_HI_TAG, SURR_W'($urandom)};
      1:       return {SURR_LO_TAG, SURR_W'($urandom)};
      2:       return UNIT_W'($urandom_range(0, 31));
      3:       return UNIT_W'($urandom_range(16'h007f, 16'h009f));
      4:       return ($urandom_range(0, 2) == 0) ? CU_NUL :
                      ($urandom_range(0, 1) == 0) ? CU_CR : CU_LF;
      default: return UNIT_W'($urandom);
    endcase
  endfunction

  // Send one line of mostly well-formed text, usually closed by a last unit.
  task automatic send_random_string();
    int len;
    int pick;
    bit mark;
    bit end_here;
    len  = $urandom_range(1, 30);
    mark = ($urandom_range(0, 99) < 85);
    for (int i = 0; i < len; i++) begin
      pick = $urandom_range(0, 99);
      end_here = mark && (i == len - 1);
      if (pick < 70) begin
        send_unit(pick_text_unit(), end_here);
      end else if (pick < 85) begin
        send_unit({SURR_HI_TAG, SURR_W'($urandom)}, 1'b0);
        send_unit({SURR_LO_TAG, SURR_W'($urandom)}, end_here);
      end else begin
        send_unit(pick_noise_unit(), end_here);
      end
    end
  endtask

  // Check the register value after reset.
  task automatic test_reset_value();
    cfg_read_check();
  endtask

  // Decode text, controls and surrogate pairs under the reset limit.
  task automatic test_decode();
    send_unit(16'h0041, 1'b0);
    send_unit(16'hffff, 1'b0);
    send_unit(CU_SPACE, 1'b0);
    send_unit(16'h001f, 1'b0);
    send_unit(CU_DEL, 1'b0);
    send_unit(CU_C1_LO, 1'b0);
    send_unit(CU_C1_HI, 1'b0);
    send_unit(16'h00a0, 1'b0);
    send_unit(16'hd800, 1'b0);
    send_unit(16'hdc00, 1'b0);
    send_unit(16'hdbff, 1'b0);
    send_unit(16'hdfff, 1'b0);
    // high then high: keep only the second
    send_unit(16'hd801, 1'b0);
    send_unit(16'hdbfe, 1'b0);
    send_unit(16'hdc01, 1'b0);
    // high then plain unit, then a lone low
    send_unit(16'hd83d, 1'b0);
    send_unit(16'h0042, 1'b0);
    send_unit(16'hdfff, 1'b0);
    // high then terminator, then units while stopped
    send_unit(16'hd800, 1'b0);
    send_unit(CU_CR, 1'b0);
    send_unit(16'h0043, 1'b0);
    send_unit(16'h0044, 1'b1);
  endtask

  // Hit NUL and LF, and the last unit both while stopped and on a fresh string.
  task automatic test_terminators();
    send_unit(CU_NUL, 1'b0);
    send_unit(16'h0041, 1'b1);
    send_unit(16'h0046, 1'b0);
    send_unit(CU_LF, 1'b0);
    send_unit(CU_NUL, 1'b1);
    send_unit(16'hdbff, 1'b1);
    send_unit(16'h0048, 1'b1);
    send_unit(16'h0001, 1'b1);
  endtask

  // Limit of zero, limit of one, and a limit lowered under the current count.
  task automatic test_limits();
    wait_idle();
    set_limit(CNT_W'(0));
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0042, 1'b1);
    wait_idle();
    set_limit(CNT_W'(1));
    send_unit(16'h0041, 1'b0);
    send_unit(16'h0042, 1'b1);
    wait_idle();
    set_limit(CNT_W'(3));
    send_unit(16'h0061, 1'b0);
    send_unit(16'h0062, 1'b0);
    wait_idle();
    set_limit(CNT_W'(1));
    send_unit(16'h0063, 1'b0);
    send_unit(16'h0064, 1'b1);
    wait_idle();
  endtask

  // Run a register value above the ceiling up to the ceiling count.
  task automatic test_limit_clamp();
    set_limit({CNT_W{1'b1}});
    rx_mode = RX_RANDOM;
    for (int i = 0; i < LIMIT_MAX; i++) send_unit(pick_text_unit(), 1'b0);
    send_unit(16'h0041, 1'b1);
    wait_idle();
  endtask

  // Random lines across phases with varied limits, gaps and stalls.
  task automatic test_random();
    int target;
    int phase_start;
    logic [CNT_W-1:0] lim;
    target = sent_units + 550;
    while (sent_units < target) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0:       lim = CNT_W'(0);
        1:       lim = CNT_W'(1);
        2:       lim = CNT_W'(LIMIT_MAX);
        3:       lim = {CNT_W{1'b1}};
        4:       lim = MAX_CP_RESET;
        5:       lim = CNT_W'($urandom_range(0, 2047));
        default: lim = CNT_W'($urandom_range(2, 24));
      endcase
      set_limit(lim);
      rx_mode = rx_mode_t'($urandom_range(0, 2));
      gaps_on = ($urandom_range(0, 3) != 0);
      phase_start = sent_units;
      while (sent_units - phase_start < 60) send_random_string();
    end
    wait_idle();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_value();
    test_decode();
    test_terminators();
    test_limits();
    test_limit_clamp();
    test_random();
    repeat (8) @(posedge clk);
    if (decoded_q.size() != 0)
      note_error($sformatf("%0d predicted results never arrived", decoded_q.size()));
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/u16f_pkg.sv
rtl/core/u16f_cfg_regs.sv
rtl/core/u16f_in_stage.sv
rtl/core/u16f_decode.sv
rtl/core/u16f_out_stage.sv
rtl/core/utf16le_line_codepoint_filter.sv
rtl/core/u16f_checker.sv
dv/tb.sv
